// File: hw/rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared result kinds and register indexes for the timing wheel scheduler.
// ----------------------------------------------------------------------------
package tws_pkg;

    typedef enum logic [2:0] {
        K_ADDED      = 3'd0,
        K_WRAPPED    = 3'd1,
        K_DROPPED    = 3'd2,
        K_FIRED      = 3'd3,
        K_FIRED_DROP = 3'd4,
        K_IDLE       = 3'd5
    } t_kind;

    localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [1:0] REG_SLOTS       = 2'd1;
    localparam logic [1:0] REG_LAYERS      = 2'd2;

    localparam int INTERVAL_W = 31;
    localparam int PERIOD_W   = 16;
    localparam int KIND_W     = 3;
    localparam int POS_OUT_W  = 9;

    // Divider request from the top level to the divider.
    typedef struct packed {
        logic                  start;
        logic [INTERVAL_W-1:0] dividend;
        logic [PERIOD_W-1:0]   divisor;
    } t_div_req;

endpackage

// File: hw/rtl/tws_div.sv
// ----------------------------------------------------------------------------
// tws_div
// Restoring divider, one quotient bit per cycle (interval / tick_period).
// ----------------------------------------------------------------------------
module tws_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tws_pkg::t_div_req               i_req,
    output logic                            o_done,
    output logic [tws_pkg::INTERVAL_W-1:0]  o_quot
);
    localparam int W  = tws_pkg::INTERVAL_W;
    localparam int DW = tws_pkg::PERIOD_W;

    logic [W-1:0]  r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_d;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;

    assign w_sh  = {r_rem[DW-1:0], r_q[W-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_d    <= i_req.divisor;
                r_cnt  <= 5'(W - 1);
            end else if (r_busy) begin
                if (!w_sub[DW]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: hw/rtl/timing_wheel_scheduler_unit.sv
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_unit
// Hashed timing wheel: adds tasks to FIFO buckets and fires them on ticks.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: task_id, interval, repeat_flag ; tuser: cmd
// m_axis    out  tdata: out_task_id, position ; tuser: kind ; tlast: last
// cfg       in   index (0 tick_period, 1 slots, 2 layers), data
//
// An add is accepted, divided in 31 steps, reduced mod P from P<<31 to P,
// then its bucket count is read, the bucket written and the result emitted;
// s_axis_tready stays low meanwhile. A tick emits each entry of the cursor's
// bucket, re-armed first (divide, reduction, bucket write) if repeat_flag is
// set; an idle tick emits one K_IDLE. A cursor left beyond P by a register
// change is reduced mod P first. Reset clears the count memory of all
// MAX_SLOTS*MAX_LAYERS positions while s_axis_tready is low. Results sit in
// one output register; the sequencer waits while it is full and not taken.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler_unit #(
    parameter int MAX_SLOTS    = 64,
    parameter int MAX_LAYERS   = 8,
    parameter int BUCKET_DEPTH = 8,
    parameter int ID_BITS      = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // task_id, interval, repeat_flag
    input  logic                 s_axis_tuser,   // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // out_task_id, position
    output logic [2:0]           m_axis_tuser,   // kind
    output logic                 m_axis_tlast,   // last
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    localparam int NPOS  = MAX_SLOTS * MAX_LAYERS;
    localparam int PW    = (NPOS > 1) ? $clog2(NPOS) : 1;
    localparam int BW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CW    = $clog2(BUCKET_DEPTH + 1);
    localparam int SW    = $clog2(MAX_SLOTS + 1);
    localparam int LW    = $clog2(MAX_LAYERS + 1);
    localparam int NW    = $clog2(NPOS + 1);
    localparam int EW    = ID_BITS + tws_pkg::INTERVAL_W + 1;
    localparam int IW    = tws_pkg::INTERVAL_W;
    localparam int SMW   = IW + PW + 1;
    localparam int PRW   = tws_pkg::PERIOD_W + NW;
    localparam int CMPW  = (PRW > IW) ? PRW : IW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CRED, S_DIV, S_MOD, S_RDCNT, S_INS, S_EMIT,
        S_TRD, S_TCNT, S_FRD, S_FENT, S_FEMIT, S_NEXT
    } t_state;

    // Config registers.
    logic [15:0] r_period;
    logic [6:0]  r_slots;
    logic [3:0]  r_layers;

    // Count and entry memories.
    logic [CW-1:0] r_cnt_mem [NPOS];
    logic [EW-1:0] r_ent_mem [NPOS*BUCKET_DEPTH];
    logic [CW-1:0] r_cnt_rd;
    logic [EW-1:0] r_ent_rd;

    t_state         r_state;
    logic [PW-1:0]  r_cursor;
    logic [NW-1:0]  r_p;
    logic [PW-1:0]  r_clr;
    logic [ID_BITS-1:0] r_id;
    logic [IW-1:0]  r_iv;
    logic           r_rep;
    logic           r_tick;
    logic [SMW-1:0] r_sum;
    logic [4:0]     r_sh;
    logic [PW-1:0]  r_where;
    logic           r_wrap;
    logic [CW-1:0]  r_n;
    logic [BW-1:0]  r_i;
    logic [tws_pkg::KIND_W-1:0] r_kind;
    logic [PRW-1:0] r_prod;

    // Output register.
    logic           r_ovalid;
    logic [tws_pkg::KIND_W-1:0] r_okind;
    logic [ID_BITS-1:0] r_oid;
    logic [PW-1:0]  r_opos;
    logic           r_olast;

    tws_pkg::t_div_req w_req;
    logic           w_done;
    logic [IW-1:0]  w_quot;

    logic [SW-1:0]  w_s;
    logic [LW-1:0]  w_l;
    logic [NW-1:0]  w_np;
    logic [15:0]    w_tp;
    logic           w_out_free;
    logic           w_oload;
    logic [SMW-1:0] w_pshift;
    logic [SMW-1:0] w_msub;

    always_comb begin
        w_s = (r_slots == 7'd0) ? SW'(1)
            : (32'(r_slots) > MAX_SLOTS) ? SW'(MAX_SLOTS) : SW'(r_slots);
        w_l = (r_layers == 4'd0) ? LW'(1)
            : (32'(r_layers) > MAX_LAYERS) ? LW'(MAX_LAYERS) : LW'(r_layers);
        w_np = NW'(w_s * w_l);
        w_tp = (r_period == 16'd0) ? 16'd1 : r_period;
    end

    // P shifted for one restoring reduction step
    assign w_pshift = SMW'(r_p) << r_sh;
    assign w_msub   = (r_sum >= w_pshift) ? r_sum - w_pshift : r_sum;

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_oload    = ((r_state == S_EMIT) || (r_state == S_FEMIT)) && w_out_free;

    always_comb begin
        w_req.start    = (r_state == S_IDLE && s_axis_tvalid && !s_axis_tuser)
                      || (r_state == S_FENT && r_ent_rd[0]);
        w_req.dividend = (r_state == S_IDLE) ? s_axis_tdata[8 +: IW] : r_ent_rd[IW:1];
        w_req.divisor  = w_tp;
    end

    tws_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd1;
            r_slots  <= 7'd64;
            r_layers <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tws_pkg::REG_TICK_PERIOD: r_period <= i_cfg_data;
                tws_pkg::REG_SLOTS:       r_slots  <= i_cfg_data[6:0];
                tws_pkg::REG_LAYERS:      r_layers <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Memory ports: one read, one write each.
    logic          w_cwe;
    logic [PW-1:0] w_caddr_w;
    logic [CW-1:0] w_cwd;
    logic [PW-1:0] w_caddr_r;
    logic          w_ewe;
    logic [PW+BW-1:0] w_eaddr_w;
    logic [PW+BW-1:0] w_eaddr_r;

    always_comb begin
        w_cwe     = 1'b0;
        w_caddr_w = r_where;
        w_cwd     = r_cnt_rd + CW'(1);
        w_ewe     = 1'b0;
        w_eaddr_w = PW'(r_where) * (PW+BW)'(BUCKET_DEPTH) + (PW+BW)'(r_cnt_rd);
        w_caddr_r = (r_state == S_TRD) ? r_cursor : r_where;
        w_eaddr_r = (PW+BW)'(PW'(r_cursor) * (PW+BW)'(BUCKET_DEPTH)) + (PW+BW)'(r_i);
        if (r_state == S_CLEAR) begin
            w_cwe = 1'b1; w_caddr_w = r_clr; w_cwd = '0;
        end else if (r_state == S_INS && 32'(r_cnt_rd) < BUCKET_DEPTH) begin
            w_cwe = 1'b1; w_ewe = 1'b1;
        end else if (r_state == S_TCNT && r_cnt_rd != '0) begin
            w_cwe = 1'b1; w_caddr_w = r_cursor; w_cwd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cwe) r_cnt_mem[w_caddr_w] <= w_cwd;
        r_cnt_rd <= r_cnt_mem[w_caddr_r];
        if (w_ewe) r_ent_mem[w_eaddr_w] <= {r_id, r_iv, r_rep};
        r_ent_rd <= r_ent_mem[w_eaddr_r];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cursor <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && !w_oload) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PW'(1);
                    if (32'(r_clr) == NPOS - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_p    <= w_np;
                    r_prod <= PRW'(w_tp) * PRW'(w_np);
                    if (s_axis_tvalid) begin
                        r_tick <= s_axis_tuser;
                        r_id   <= ID_BITS'(s_axis_tdata[7:0]);
                        r_iv   <= s_axis_tdata[8 +: IW];
                        r_rep  <= s_axis_tdata[8+IW];
                        if (32'(r_cursor) >= 32'(w_np)) begin
                            // cursor past a shrunk wheel: reduce it first
                            r_sh    <= 5'(PW - 1);
                            r_state <= S_CRED;
                        end else begin
                            r_state <= s_axis_tuser ? S_TRD : S_DIV;
                        end
                    end
                end
                S_CRED: begin
                    // restoring reduction of the cursor, one shift of P per cycle
                    if (SMW'(r_cursor) >= w_pshift)
                        r_cursor <= PW'(SMW'(r_cursor) - w_pshift);
                    r_sh <= r_sh - 5'd1;
                    if (r_sh == '0) r_state <= r_tick ? S_TRD : S_DIV;
                end
                S_DIV: begin
                    if (w_done) begin
                        r_sum   <= SMW'(w_quot) + SMW'(r_cursor);
                        r_wrap  <= CMPW'(r_iv) > CMPW'(r_prod);
                        r_sh    <= 5'(IW);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    // restoring reduction of the sum, P<<31 down to P
                    r_sum <= w_msub;
                    r_sh  <= r_sh - 5'd1;
                    if (r_sh == '0) begin
                        r_where <= PW'(w_msub);
                        r_state <= S_RDCNT;
                    end
                end
                S_RDCNT: r_state <= S_INS;
                S_INS: begin
                    if (r_tick) begin
                        r_kind  <= (32'(r_cnt_rd) >= BUCKET_DEPTH)
                                 ? tws_pkg::K_FIRED_DROP : tws_pkg::K_FIRED;
                        r_state <= S_FEMIT;
                    end else begin
                        r_kind  <= (32'(r_cnt_rd) >= BUCKET_DEPTH) ? tws_pkg::K_DROPPED
                                 : r_wrap ? tws_pkg::K_WRAPPED : tws_pkg::K_ADDED;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_kind;
                        r_oid    <= r_id;
                        r_opos   <= r_where;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_TRD: r_state <= S_TCNT;
                S_TCNT: begin
                    r_n <= r_cnt_rd;
                    r_i <= '0;
                    if (r_cnt_rd == '0) begin
                        r_kind  <= tws_pkg::K_IDLE;
                        r_id    <= '0;
                        r_state <= S_FEMIT;
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_FRD: r_state <= S_FENT;
                S_FENT: begin
                    r_id  <= r_ent_rd[EW-1:IW+1];
                    r_iv  <= r_ent_rd[IW:1];
                    r_rep <= r_ent_rd[0];
                    r_kind <= tws_pkg::K_FIRED;
                    r_state <= r_ent_rd[0] ? S_DIV : S_FEMIT;
                end
                S_FEMIT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_kind;
                        r_oid    <= r_id;
                        r_opos   <= r_cursor;
                        r_olast  <= (r_kind == tws_pkg::K_IDLE)
                                 || (CW'(r_i) + CW'(1) == r_n);
                        if (r_kind == tws_pkg::K_IDLE || CW'(r_i) + CW'(1) == r_n)
                            r_state <= S_NEXT;
                        else begin
                            r_i     <= r_i + BW'(1);
                            r_state <= S_FRD;
                        end
                    end
                end
                S_NEXT: begin
                    r_cursor <= (NW'(r_cursor) + NW'(1) == r_p) ? '0 : r_cursor + PW'(1);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {7'd0, tws_pkg::POS_OUT_W'(r_opos), 8'(r_oid)};
endmodule

// File: hw/rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks of the timing wheel scheduler.
// ----------------------------------------------------------------------------
module tws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= tws_pkg::K_IDLE)
        else $error("bad kind");
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == tws_pkg::K_IDLE
            || m_axis_tuser <= tws_pkg::K_DROPPED)
            |-> m_axis_tlast)
        else $error("single result not marked last");
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == tws_pkg::K_IDLE |-> m_axis_tdata[7:0] == 8'd0)
        else $error("idle tick with task id");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken mid tick");
endmodule

bind timing_wheel_scheduler_unit tws_checker u_tws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
